// ===== hw/rtl/rsr_pkg.sv =====
// shared constants for the replacement selection run generator
package rsr_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int KEY_BITS_DEF  = 32;
  localparam int REF_BITS_DEF  = 16;

  localparam int RUN_BITS      = 16;
  localparam int SIZE_BITS     = 6;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 6'd32;

  localparam int APB_ADDR_BITS = 2;
  localparam int APB_DATA_BITS = 32;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_MEMORY_SIZE = 2'd0;

endpackage

// ===== hw/rtl/rsr_store.sv =====
// record slot store: one write port, one registered read port
module rsr_store #(
  parameter int CAPACITY = rsr_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = rsr_pkg::KEY_BITS_DEF,
  parameter int REF_BITS = rsr_pkg::REF_BITS_DEF,
  localparam int IDX_BITS = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [IDX_BITS-1:0]        waddr,
  input  logic signed [KEY_BITS-1:0] wkey,
  input  logic [REF_BITS-1:0]        wref,
  input  logic                       re,
  input  logic [IDX_BITS-1:0]        raddr,
  output logic signed [KEY_BITS-1:0] rd_key,
  output logic [REF_BITS-1:0]        rd_ref
);

  logic signed [KEY_BITS-1:0] key_mem [CAPACITY];
  logic [REF_BITS-1:0]        ref_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      ref_mem[waddr] <= wref;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_key <= key_mem[raddr];
      rd_ref <= ref_mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/rsr_min_scan.sv =====
// minimum search over the candidate slots with one shared comparator
module rsr_min_scan #(
  parameter int CAPACITY = rsr_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = rsr_pkg::KEY_BITS_DEF,
  parameter int REF_BITS = rsr_pkg::REF_BITS_DEF,
  localparam int IDX_BITS = $clog2(CAPACITY),
  localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [CAPACITY-1:0]        cand,
  output logic                       rd_en,
  output logic [IDX_BITS-1:0]        rd_addr,
  input  logic signed [KEY_BITS-1:0] rd_key,
  input  logic [REF_BITS-1:0]        rd_ref,
  output logic                       done,
  output logic [IDX_BITS-1:0]        best_idx,
  output logic signed [KEY_BITS-1:0] best_key,
  output logic [REF_BITS-1:0]        best_ref
);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic                pend;
  logic [IDX_BITS-1:0] pend_idx;
  logic                found;
  logic                issue;
  logic                take;

  assign issue   = busy && (cnt < CNT_BITS'(CAPACITY));
  assign rd_en   = issue;
  assign rd_addr = cnt[IDX_BITS-1:0];
  assign done    = busy && !issue && !pend;

  // strict less keeps the lower slot on equal keys
  assign take = pend && cand[pend_idx] && (!found || (rd_key < best_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pend  <= 1'b0;
      found <= 1'b0;
      cnt   <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      pend  <= 1'b0;
      found <= 1'b0;
      cnt   <= '0;
    end else begin
      pend <= issue;
      if (issue) begin
        cnt <= cnt + CNT_BITS'(1);
      end
      if (done) begin
        busy <= 1'b0;
      end
      if (take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= cnt[IDX_BITS-1:0];
    if (take) begin
      best_idx <= pend_idx;
      best_key <= rd_key;
      best_ref <= rd_ref;
    end
  end

endmodule

// ===== hw/rtl/replacement_selection_runs.sv =====
// replacement selection run generator: top level with sequencer and register port
// a record that only fills the store is written straight into its slot; a replacing record
// waits on the sequential minimum scan over the slot memory
// (one read and one compare per cycle); a final record then flushes each stored record
// through its own scan, and every emitted record may also wait on out_ready
// synchronous reset clears run state, masks and fill count and sets memory_size to 32;
// the slot memory is not cleared
module replacement_selection_runs #(
  parameter int CAPACITY = rsr_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = rsr_pkg::KEY_BITS_DEF,
  parameter int REF_BITS = rsr_pkg::REF_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rsr_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [rsr_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [rsr_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [KEY_BITS-1:0]            record_key,
  input  logic [REF_BITS-1:0]                   record_ref,
  input  logic                                  final_record,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [KEY_BITS-1:0]            out_key,
  output logic [REF_BITS-1:0]                   out_ref,
  output logic [rsr_pkg::RUN_BITS-1:0]          run_number,
  output logic                                  run_start,
  output logic                                  last_result
);

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_DECIDE     = 6'b000010,
    S_SCAN       = 6'b000100,
    S_EMIT       = 6'b001000,
    S_FLUSH_INIT = 6'b010000,
    S_FLUSH      = 6'b100000
  } state_t;

  state_t state;

  logic [rsr_pkg::SIZE_BITS-1:0] memory_size;
  logic [CAPACITY-1:0]           valid_mask;
  logic [CAPACITY-1:0]           frozen_mask;
  logic [CAPACITY-1:0]           work_mask;
  logic [CNT_BITS-1:0]           fill_count;
  logic [rsr_pkg::RUN_BITS-1:0]  current_run;
  logic                          run_opening;
  logic                          flushing;
  logic                          frozen_phase;
  logic signed [KEY_BITS-1:0]    key_q;
  logic [REF_BITS-1:0]           ref_q;
  logic                          fin_q;
  logic [CAPACITY-1:0]           scan_cand;
  logic                          scan_start;

  logic                          scan_done;
  logic [IDX_BITS-1:0]           best_idx;
  logic signed [KEY_BITS-1:0]    best_key;
  logic [REF_BITS-1:0]           best_ref;
  logic                          rd_en;
  logic [IDX_BITS-1:0]           rd_addr;
  logic signed [KEY_BITS-1:0]    rd_key;
  logic [REF_BITS-1:0]           rd_ref;

  logic [CNT_BITS-1:0]           eff_size;
  logic [CAPACITY-1:0]           win;
  logic [CAPACITY-1:0]           fill_bit;
  logic [CAPACITY-1:0]           best_bit;
  logic                          fill_mode;
  logic [CAPACITY-1:0]           cand_live;
  logic [CAPACITY-1:0]           frozen_next;
  logic [CAPACITY-1:0]           work_next;
  logic [CAPACITY-1:0]           flush_open;
  logic [CAPACITY-1:0]           flush_frozen;
  logic [rsr_pkg::RUN_BITS-1:0]  run_inc;
  logic                          out_free;
  logic                          cfg_write;
  logic                          mem_we;
  logic [IDX_BITS-1:0]           mem_waddr;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == rsr_pkg::ADDR_MEMORY_SIZE);
  assign prdata    = (paddr == rsr_pkg::ADDR_MEMORY_SIZE)
                   ? rsr_pkg::APB_DATA_BITS'(memory_size) : '0;

  // size clamped to one slot minimum and the store capacity maximum
  always_comb begin
    if (memory_size == '0) begin
      eff_size = CNT_BITS'(1);
    end else if (memory_size > rsr_pkg::SIZE_BITS'(CAPACITY)) begin
      eff_size = CNT_BITS'(CAPACITY);
    end else begin
      eff_size = CNT_BITS'(memory_size);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      win[i]      = CNT_BITS'(i) < eff_size;
      fill_bit[i] = fill_count == CNT_BITS'(i);
      best_bit[i] = best_idx == IDX_BITS'(i);
    end
  end

  assign fill_mode    = fill_count < eff_size;
  assign cand_live    = valid_mask & win & ~frozen_mask;
  assign frozen_next  = frozen_mask | ((key_q < best_key) ? best_bit : '0);
  assign work_next    = work_mask & ~best_bit;
  assign flush_open   = work_mask & ~frozen_mask;
  assign flush_frozen = work_mask & frozen_mask;
  assign run_inc      = (current_run == '1) ? current_run
                                            : current_run + rsr_pkg::RUN_BITS'(1);
  assign out_free     = !out_valid || out_ready;
  assign in_ready     = (state == S_IDLE);

  assign mem_we    = ((state == S_DECIDE) && fill_mode)
                   || ((state == S_EMIT) && out_free && !flushing);
  assign mem_waddr = (state == S_DECIDE) ? fill_count[IDX_BITS-1:0] : best_idx;

  rsr_store #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .REF_BITS (REF_BITS)
  ) u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wkey   (key_q),
    .wref   (ref_q),
    .re     (rd_en),
    .raddr  (rd_addr),
    .rd_key (rd_key),
    .rd_ref (rd_ref)
  );

  rsr_min_scan #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .REF_BITS (REF_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .cand     (scan_cand),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_ref   (rd_ref),
    .done     (scan_done),
    .best_idx (best_idx),
    .best_key (best_key),
    .best_ref (best_ref)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      memory_size  <= rsr_pkg::SIZE_RESET;
      valid_mask   <= '0;
      frozen_mask  <= '0;
      work_mask    <= '0;
      fill_count   <= '0;
      current_run  <= '0;
      run_opening  <= 1'b1;
      flushing     <= 1'b0;
      frozen_phase <= 1'b0;
      scan_start   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      scan_start <= 1'b0;
      if (cfg_write) begin
        memory_size <= pwdata[rsr_pkg::SIZE_BITS-1:0];
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_q <= record_key;
            ref_q <= record_ref;
            fin_q <= final_record;
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (fill_mode) begin
            valid_mask  <= valid_mask | fill_bit;
            frozen_mask <= frozen_mask & ~fill_bit;
            fill_count  <= fill_count + CNT_BITS'(1);
            state       <= fin_q ? S_FLUSH_INIT : S_IDLE;
          end else begin
            // whole window frozen after a size change: thaw before selecting
            if (cand_live == '0) begin
              frozen_mask <= '0;
              scan_cand   <= valid_mask & win;
              if (!run_opening) begin
                current_run <= run_inc;
                run_opening <= 1'b1;
              end
            end else begin
              scan_cand <= cand_live;
            end
            flushing   <= 1'b0;
            scan_start <= 1'b1;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (scan_done) begin
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_key    <= best_key;
            out_ref    <= best_ref;
            run_number <= current_run;
            run_start  <= run_opening;
            if (flushing) begin
              work_mask   <= work_next;
              last_result <= (work_next == '0);
              run_opening <= 1'b0;
              state       <= S_FLUSH;
            end else begin
              last_result <= !fin_q;
              if ((frozen_next & win) == (valid_mask & win)) begin
                frozen_mask <= '0;
                current_run <= run_inc;
                run_opening <= 1'b1;
              end else begin
                frozen_mask <= frozen_next;
                run_opening <= 1'b0;
              end
              state <= fin_q ? S_FLUSH_INIT : S_IDLE;
            end
          end
        end

        S_FLUSH_INIT: begin
          work_mask    <= valid_mask;
          frozen_phase <= 1'b0;
          flushing     <= 1'b1;
          state        <= S_FLUSH;
        end

        S_FLUSH: begin
          if (flush_open != '0) begin
            scan_cand  <= flush_open;
            scan_start <= 1'b1;
            state      <= S_SCAN;
          end else if (flush_frozen != '0) begin
            // frozen group opens its own run unless the current one is still empty
            if (!frozen_phase) begin
              frozen_phase <= 1'b1;
              if (!run_opening) begin
                current_run <= run_inc;
                run_opening <= 1'b1;
              end
            end
            scan_cand  <= flush_frozen;
            scan_start <= 1'b1;
            state      <= S_SCAN;
          end else begin
            valid_mask  <= '0;
            frozen_mask <= '0;
            fill_count  <= '0;
            current_run <= '0;
            run_opening <= 1'b1;
            flushing    <= 1'b0;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
